/* hw/rtl/mrfc_pkg.sv */
package mrfc_pkg;

  // fixed widths of the frame counter and crc
  localparam int CountW = 6;
  localparam int CrcW = 16;

  // default frame length in bytes, legal range 3 to 64
  localparam int FrameLenDefault = 7;

  // reflected crc-16/modbus constants
  localparam logic [CrcW-1:0] CrcInit = 16'hFFFF;
  localparam logic [CrcW-1:0] CrcPoly = 16'hA001;

  // one received byte of a reply frame
  typedef struct packed {
    logic [7:0] rx_byte;
    logic       frame_start;
  } byte_item_t;

  // one checked frame
  typedef struct packed {
    logic [7:0] value_byte;
    logic       crc_good;
  } result_t;

  // one byte step of the reflected crc, eight shift and xor steps
  function automatic logic [CrcW-1:0] crc16_byte(input logic [CrcW-1:0] crc_in,
                                                 input logic [7:0] data);
    logic [CrcW-1:0] crc;
    crc = crc_in ^ {8'h00, data};
    for (int i = 0; i < 8; i++) begin
      if (crc[0]) begin
        crc = (crc >> 1) ^ CrcPoly;
      end else begin
        crc = crc >> 1;
      end
    end
    return crc;
  endfunction

endpackage

/* hw/rtl/mrfc_in_reg.sv */
module mrfc_in_reg (
  input  logic                clk,
  input  logic                rst,
  input  logic                byte_valid,
  output logic                byte_stall,
  input  mrfc_pkg::byte_item_t byte_item,
  input  logic                take,
  output logic                q_valid,
  output mrfc_pkg::byte_item_t q_item
);

  logic                 valid;
  logic                 valid_next;
  logic                 accept;
  mrfc_pkg::byte_item_t item;

  // hold the item while the core cannot consume it
  assign byte_stall = valid && !take;
  assign accept     = byte_valid && !byte_stall;
  assign valid_next = accept || (valid && !take);

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else begin
      valid <= valid_next;
    end
  end

  // payload register
  always_ff @(posedge clk) begin
    if (accept) begin
      item <= byte_item;
    end
  end

  assign q_valid = valid;
  assign q_item  = item;

endmodule

/* hw/rtl/mrfc_core.sv */
module mrfc_core #(
  parameter int FRAME_LEN = mrfc_pkg::FrameLenDefault
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 q_valid,
  input  mrfc_pkg::byte_item_t q_item,
  input  logic                 out_free,
  output logic                 take,
  output logic                 res_load,
  output mrfc_pkg::result_t    res_item
);

  localparam logic [mrfc_pkg::CountW-1:0] PosHeld = mrfc_pkg::CountW'(FRAME_LEN - 3);
  localparam logic [mrfc_pkg::CountW-1:0] PosLow  = mrfc_pkg::CountW'(FRAME_LEN - 2);
  localparam logic [mrfc_pkg::CountW-1:0] PosLast = mrfc_pkg::CountW'(FRAME_LEN - 1);

  logic [mrfc_pkg::CountW-1:0] byte_count;
  logic [mrfc_pkg::CountW-1:0] byte_count_next;
  logic [mrfc_pkg::CrcW-1:0]   crc_acc;
  logic [mrfc_pkg::CrcW-1:0]   crc_acc_next;
  logic [7:0]                  crc_low_seen;
  logic [7:0]                  held_value;
  logic [mrfc_pkg::CountW-1:0] pos;
  logic [mrfc_pkg::CrcW-1:0]   crc_in;
  logic [mrfc_pkg::CrcW-1:0]   crc_new;
  logic                        last;

  // position and running crc of the item, a frame start restarts both
  assign pos    = q_item.frame_start ? '0 : byte_count;
  assign crc_in = q_item.frame_start ? mrfc_pkg::CrcInit : crc_acc;
  assign crc_new = (pos < PosLow) ? mrfc_pkg::crc16_byte(crc_in, q_item.rx_byte) : crc_in;
  assign last   = (pos == PosLast);

  // a final byte waits until the result register is free
  assign take     = q_valid && (!last || out_free);
  assign res_load = take && last;

  // result, crc compared low byte first
  assign res_item.value_byte = held_value;
  assign res_item.crc_good   = ({q_item.rx_byte, crc_low_seen} == crc_new);

  // next frame state
  always_comb begin
    if (last) begin
      byte_count_next = '0;
      crc_acc_next    = mrfc_pkg::CrcInit;
    end else begin
      byte_count_next = pos + 1'b1;
      crc_acc_next    = crc_new;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_count   <= '0;
      crc_acc      <= mrfc_pkg::CrcInit;
      crc_low_seen <= '0;
      held_value   <= '0;
    end else if (take) begin
      byte_count <= byte_count_next;
      crc_acc    <= crc_acc_next;
      if (pos == PosHeld) begin
        held_value <= q_item.rx_byte;
      end
      if (pos == PosLow) begin
        crc_low_seen <= q_item.rx_byte;
      end
    end
  end

`ifndef ASSERT_OFF
  a_count_in_frame: assert property (@(posedge clk) disable iff (rst)
    byte_count <= PosLast)
    else $error("frame position ran past the frame end");

  a_restart_after_last: assert property (@(posedge clk) disable iff (rst)
    res_load |=> (byte_count == '0) && (crc_acc == mrfc_pkg::CrcInit))
    else $error("frame state not restarted after final byte");

  a_no_load_when_full: assert property (@(posedge clk) disable iff (rst)
    res_load |-> out_free)
    else $error("result loaded while result register busy");

  a_hold_when_stuck: assert property (@(posedge clk) disable iff (rst)
    q_valid && !take |=> $stable(byte_count) && $stable(crc_acc))
    else $error("frame state moved while item was held");
`endif

endmodule

/* hw/rtl/mrfc_out_reg.sv */
module mrfc_out_reg (
  input  logic              clk,
  input  logic              rst,
  input  logic              res_load,
  input  mrfc_pkg::result_t res_item,
  output logic              out_free,
  output logic              result_valid,
  input  logic              result_stall,
  output mrfc_pkg::result_t result_item
);

  logic              valid;
  logic              valid_next;
  mrfc_pkg::result_t item;

  // free when empty or being taken this cycle
  assign out_free   = !valid || !result_stall;
  assign valid_next = res_load || (valid && result_stall);

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else begin
      valid <= valid_next;
    end
  end

  // payload register
  always_ff @(posedge clk) begin
    if (res_load) begin
      item <= res_item;
    end
  end

  assign result_valid = valid;
  assign result_item  = item;

endmodule

/* hw/rtl/modbus_reply_frame_checker_top.sv */
// Modbus RTU reply frame checker.
// Input channel byte_valid / byte_stall / byte_item carries one reply byte per
// item with a frame_start flag; frame_start restarts the frame at position 0.
// FRAME_LEN bytes make one frame: crc-16/modbus runs over all but the last two,
// the byte three from the end is kept, and the last two bytes are the received
// crc, low byte first.
// Output channel result_valid / result_stall / result_item gives one item per
// frame, on its final byte: the kept data byte and a crc match flag.
// A final byte is held by the input register, its result by the result
// register. Throughput is one byte per cycle unless a final byte waits for
// the result register, set by the one crc byte step after the input register.
// Reset clears the frame position, loads the crc with 0xFFFF and empties both
// registers. When the receiver stalls, the result is held; a further final
// byte then waits in the input register, and byte_stall rises only once that
// register is occupied, so non-final bytes keep flowing.
module modbus_reply_frame_checker_top #(
  parameter int FRAME_LEN = mrfc_pkg::FrameLenDefault
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 byte_valid,
  output logic                 byte_stall,
  input  mrfc_pkg::byte_item_t byte_item,
  output logic                 result_valid,
  input  logic                 result_stall,
  output mrfc_pkg::result_t    result_item
);

  logic                 q_valid;
  mrfc_pkg::byte_item_t q_item;
  logic                 take;
  logic                 out_free;
  logic                 res_load;
  mrfc_pkg::result_t    res_item;

  // input register
  mrfc_in_reg u_in_reg (
    .clk        (clk),
    .rst        (rst),
    .byte_valid (byte_valid),
    .byte_stall (byte_stall),
    .byte_item  (byte_item),
    .take       (take),
    .q_valid    (q_valid),
    .q_item     (q_item)
  );

  // crc and frame tracking
  mrfc_core #(
    .FRAME_LEN (FRAME_LEN)
  ) u_core (
    .clk      (clk),
    .rst      (rst),
    .q_valid  (q_valid),
    .q_item   (q_item),
    .out_free (out_free),
    .take     (take),
    .res_load (res_load),
    .res_item (res_item)
  );

  // result register
  mrfc_out_reg u_out_reg (
    .clk          (clk),
    .rst          (rst),
    .res_load     (res_load),
    .res_item     (res_item),
    .out_free     (out_free),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result_item  (result_item)
  );

endmodule
